// ----- hdl/adamw_parameter_update_assert.svh -----
`ifndef ADAMW_PARAMETER_UPDATE_ASSERT_SVH
`define ADAMW_PARAMETER_UPDATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ADPU_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ADPU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/adpu_pkg.sv -----
`default_nettype none
package adpu_pkg;

   localparam int FRAC_BITS = 24;
   localparam logic [24:0] ONE_Q = 25'h100_0000;
   localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

   localparam logic [2:0] CSR_LEARN_RATE   = 3'd0;
   localparam logic [2:0] CSR_FIRST_DECAY  = 3'd1;
   localparam logic [2:0] CSR_SECOND_DECAY = 3'd2;
   localparam logic [2:0] CSR_GUARD_TERM   = 3'd3;
   localparam logic [2:0] CSR_DECAY_WEIGHT = 3'd4;

   localparam logic [24:0] RST_LEARN_RATE   = 25'd16777;
   localparam logic [23:0] RST_FIRST_DECAY  = 24'd15099494;
   localparam logic [23:0] RST_SECOND_DECAY = 24'd16760439;
   localparam logic [24:0] RST_GUARD_TERM   = 25'd1;
   localparam logic [24:0] RST_DECAY_WEIGHT = 25'd167772;

   localparam logic [6:0] CNT_HAT   = 7'd56;
   localparam logic [6:0] CNT_STEP  = 7'd81;

   typedef struct packed {
      logic [24:0] learn_rate;
      logic [23:0] first_decay;
      logic [23:0] second_decay;
      logic [24:0] guard_term;
      logic [24:0] decay_weight;
   } cfg_type;

   typedef struct packed {
      logic [11:0] elem_index;
      logic [31:0] gradient;
      logic [31:0] weight_in;
      logic [24:0] beta1_power;
      logic [24:0] beta2_power;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [6:0]  count;
      logic [80:0] num;
      logic [40:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef struct packed {
      logic deq;
      logic we_m;
      logic we_v;
      logic rsp_load;
      logic root_start;
   } back_ctl_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
      ST_DECAY, ST_MHAT, ST_VHAT, ST_ROOT, ST_SMUL, ST_SDIV_GO, ST_SDIV,
      ST_FIN, ST_OUT
   } back_state_type;

endpackage
`default_nettype wire

// ----- hdl/adamw_parameter_update.sv -----
// When the bias-corrected step applies, the shared one-bit-per-cycle divider forms
// both bias corrections and then the step quotient, with the bit-serial root between.
// One item is processed at a time; a two-entry queue takes new items meanwhile.
// Reset: synchronous; registers take their defaults, powers return to one, and a
// clearing pass zeroes both moment memories while req_ready stays low.
`default_nettype none
module adamw_parameter_update import adpu_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [11:0] req_elem_index,
   input  wire  [31:0] req_gradient,
   input  wire  [31:0] req_weight_in,
   input  wire         req_new_pass,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_weight_out,
   output logic        rsp_saturated,
   input  wire         csr_write_en,
   input  wire  [2:0]  csr_index,
   input  wire  [24:0] csr_data
);

   cfg_type       cfg_ff;
   item_type      head;
   logic          head_valid, pop, clearing, root_start;
   div_cmd_type   div_cmd;
   logic [80:0]   div_quot;
   unit_stat_type div_stat, root_stat;
   logic [79:0]   root_value;
   logic [39:0]   root_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate   <= RST_LEARN_RATE;
         cfg_ff.first_decay  <= RST_FIRST_DECAY;
         cfg_ff.second_decay <= RST_SECOND_DECAY;
         cfg_ff.guard_term   <= RST_GUARD_TERM;
         cfg_ff.decay_weight <= RST_DECAY_WEIGHT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LEARN_RATE:   cfg_ff.learn_rate   <= csr_data;
            CSR_FIRST_DECAY:  cfg_ff.first_decay  <= csr_data[23:0];
            CSR_SECOND_DECAY: cfg_ff.second_decay <= csr_data[23:0];
            CSR_GUARD_TERM:   cfg_ff.guard_term   <= csr_data;
            CSR_DECAY_WEIGHT: cfg_ff.decay_weight <= csr_data;
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   adpu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .block          (clearing),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_elem_index (req_elem_index),
      .req_gradient   (req_gradient),
      .req_weight_in  (req_weight_in),
      .req_new_pass   (req_new_pass),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop)
   );

   adpu_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   adpu_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (root_value),
      .root  (root_res),
      .stat  (root_stat)
   );

   adpu_back #(.DEPTH(DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop),
      .clearing       (clearing),
      .div_cmd        (div_cmd),
      .div_quot       (div_quot),
      .div_stat       (div_stat),
      .root_start     (root_start),
      .root_value     (root_value),
      .root_res       (root_res),
      .root_stat      (root_stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_weight_out (rsp_weight_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
`default_nettype wire

// ----- hdl/adpu_front.sv -----
`default_nettype none
module adpu_front import adpu_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire cfg_type cfg,
   input  wire         block,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [11:0] req_elem_index,
   input  wire  [31:0] req_gradient,
   input  wire  [31:0] req_weight_in,
   input  wire         req_new_pass,
   output item_type    head,
   output logic        head_valid,
   input  wire         pop
);

   logic [24:0] p1_ff, p2_ff, p1_in, p2_in;
   logic [48:0] p1_prod, p2_prod;
   item_type    q_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   assign req_ready  = !block && (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = (cnt_ff != 2'd0);

   assign p1_prod = 49'(p1_ff) * 49'(cfg.first_decay);
   assign p2_prod = 49'(p2_ff) * 49'(cfg.second_decay);

   always_comb begin
      p1_in = p1_ff;
      p2_in = p2_ff;
      if (push && req_new_pass) begin
         p1_in = p1_prod[48:24];
         p2_in = p2_prod[48:24];
      end
      cnt_in = cnt_ff + 2'(push) - 2'(pop && head_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff     <= ONE_Q;
         p2_ff     <= ONE_Q;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && head_valid) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{elem_index: req_elem_index, gradient: req_gradient,
                              weight_in: req_weight_in, beta1_power: p1_in,
                              beta2_power: p2_in};
      end
   end

endmodule
`default_nettype wire

// ----- hdl/adpu_divider.sv -----
`default_nettype none
module adpu_divider import adpu_pkg::*; (
   input  wire             clock,
   input  wire             reset,
   input  wire div_cmd_type cmd,
   output logic [80:0]     quot,
   output unit_stat_type   stat
);

   logic [80:0] num_ff, q_ff;
   logic [40:0] den_ff, rem_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [41:0] rem_sh, rem_dif;
   logic        fits;

   assign rem_sh  = {rem_ff, num_ff[80]};
   assign rem_dif = rem_sh - {1'b0, den_ff};
   assign fits    = rem_sh >= {1'b0, den_ff};

   assign quot = q_ff;
   assign stat = '{busy: busy_ff, done: done_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.count;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && !busy_ff) begin
         num_ff <= cmd.num;
         den_ff <= cmd.den;
         rem_ff <= 41'd0;
         q_ff   <= 81'd0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[79:0], 1'b0};
         rem_ff <= fits ? rem_dif[40:0] : rem_sh[40:0];
         q_ff   <= {q_ff[79:0], fits};
      end
   end

endmodule
`default_nettype wire

// ----- hdl/adpu_root.sv -----
`default_nettype none
module adpu_root import adpu_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           start,
   input  wire  [79:0]   value,
   output logic [39:0]   root,
   output unit_stat_type stat
);

   logic [79:0] val_ff;
   logic [39:0] root_ff;
   logic [41:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [43:0] rem_sh, trial, rem_dif;
   logic        fits;

   assign rem_sh  = {rem_ff, val_ff[79:78]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign rem_dif = rem_sh - trial;
   assign fits    = rem_sh >= trial;

   assign root = root_ff;
   assign stat = '{busy: busy_ff, done: done_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd40;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         val_ff  <= value;
         root_ff <= 40'd0;
         rem_ff  <= 42'd0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[77:0], 2'b00};
         rem_ff  <= fits ? rem_dif[41:0] : rem_sh[41:0];
         root_ff <= {root_ff[38:0], fits};
      end
   end

endmodule
`default_nettype wire

// ----- hdl/adpu_back.sv -----
`default_nettype none
`include "adamw_parameter_update_assert.svh"
module adpu_back import adpu_pkg::*; #(
   parameter int DEPTH = 4096
) (
   input  wire              clock,
   input  wire              reset,
   input  wire cfg_type     cfg,
   input  wire item_type    head,
   input  wire              head_valid,
   output logic             pop,
   output logic             clearing,
   output div_cmd_type      div_cmd,
   input  wire  [80:0]      div_quot,
   input  wire unit_stat_type div_stat,
   output logic             root_start,
   output logic [79:0]      root_value,
   input  wire  [39:0]      root_res,
   input  wire unit_stat_type root_stat,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic [31:0]      rsp_weight_out,
   output logic             rsp_saturated
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [24:0] RECIP = 25'((64'd1 << 24) / 64'(DEPTH));

   back_state_type state_ff, state_in;
   back_ctl_type   ctl;

   logic [31:0] mem_m [DEPTH];
   logic [31:0] mem_v [DEPTH];

   item_type    item_ff;
   logic [AW-1:0] addr_ff, clr_ptr_ff, wr_addr;
   logic [36:0] modq_prod;
   logic [12:0] modq_ff;
   logic [32:0] mod_r, mod_fix;
   logic [31:0] m_old_ff, v_old_ff, m_new_ff, v_new_ff, m_mag, g_mag, wr_m;
   logic signed [57:0] pa_ff, pb_ff, dw_ff;
   logic signed [57:0] pa_in, pb_in, dw_in;
   logic [63:0] g2full_ff;
   logic [39:0] g2_ff;
   logic [56:0] pv_a_ff;
   logic [48:0] pv_lo_ff;
   logic [40:0] pv_hi_ff;
   logic [24:0] dec_ff;
   logic [49:0] dec_full;
   logic [55:0] mhat_ff;
   logic [40:0] denom_ff, smag_ff;
   logic [52:0] sp_lo_ff, sp_hi_ff;
   logic [80:0] sp_num;
   logic        sat_ff, adam;
   logic [24:0] b1, c1, b2, c2;
   logic signed [25:0] b1_s, c1_s, dec_s;
   logic signed [58:0] m_sum;
   logic signed [34:0] m_sh;
   logic [65:0] v_sum;
   logic [41:0] v_sh;
   logic signed [43:0] w1, w2;
   logic [31:0] w_fin;
   logic        m_hi, m_lo, v_ovf, w_hi, w_lo;
   logic        rsp_valid_ff, rsp_sat_ff;
   logic [31:0] rsp_w_ff;

   assign b1   = {1'b0, cfg.first_decay};
   assign b2   = {1'b0, cfg.second_decay};
   assign c1   = ONE_Q - b1;
   assign c2   = ONE_Q - b2;
   assign b1_s = {1'b0, b1};
   assign c1_s = {1'b0, c1};
   assign dec_s = {1'b0, dec_ff};

   assign modq_prod = 37'(head.elem_index) * 37'(RECIP);
   assign mod_r     = 33'(item_ff.elem_index) - 33'(modq_ff) * 33'(DEPTH);
   assign mod_fix   = (mod_r >= 33'(DEPTH)) ? (mod_r - 33'(DEPTH)) : mod_r;

   assign adam = (item_ff.beta1_power < ONE_Q) && (item_ff.beta2_power < ONE_Q);

   assign g_mag = item_ff.gradient[31] ? (~item_ff.gradient + 32'd1) : item_ff.gradient;
   assign m_mag = m_new_ff[31] ? (~m_new_ff + 32'd1) : m_new_ff;

   assign pa_in = b1_s * $signed(m_old_ff);
   assign pb_in = c1_s * $signed(item_ff.gradient);
   assign dw_in = dec_s * $signed(item_ff.weight_in);

   assign m_sum = {pa_ff[57], pa_ff} + {pb_ff[57], pb_ff};
   assign m_sh  = m_sum[58:24];
   assign m_hi  = !m_sh[34] && (m_sh[33:31] != 3'b000);
   assign m_lo  = m_sh[34] && (m_sh[33:31] != 3'b111);

   assign v_sum = 66'(pv_a_ff) + 66'(pv_lo_ff) + 66'({pv_hi_ff, 24'd0});
   assign v_sh  = v_sum[65:24];
   assign v_ovf = (v_sh[41:32] != 10'd0);

   assign dec_full = 50'(cfg.learn_rate) * 50'(cfg.decay_weight);
   assign sp_num   = 81'(sp_lo_ff) + {sp_hi_ff, 28'd0};

   assign w1 = 44'($signed(item_ff.weight_in)) - 44'($signed(dw_ff[57:24]));
   assign w2 = m_new_ff[31] ? (w1 + $signed({3'b000, smag_ff}))
                            : (w1 - $signed({3'b000, smag_ff}));
   assign w_hi  = !w2[43] && (w2[42:31] != 12'd0);
   assign w_lo  = w2[43] && (w2[42:31] != 12'hFFF);
   assign w_fin = w_hi ? 32'h7FFF_FFFF : (w_lo ? 32'h8000_0000 : w2[31:0]);

   assign pop        = ctl.deq;
   assign root_start = ctl.root_start;
   assign clearing   = (state_ff == ST_CLEAR);
   assign wr_addr    = clearing ? clr_ptr_ff : addr_ff;
   assign wr_m       = clearing ? 32'd0 : m_new_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_out = rsp_w_ff;
   assign rsp_saturated  = rsp_sat_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (clr_ptr_ff == LAST) state_in = ST_IDLE;
         ST_IDLE:    if (head_valid) state_in = ST_MOD;
         ST_MOD:     state_in = ST_READ;
         ST_READ:    state_in = ST_MUL1;
         ST_MUL1:    state_in = ST_MUL2;
         ST_MUL2:    state_in = ST_MUL3;
         ST_MUL3:    state_in = ST_MUL4;
         ST_MUL4:    state_in = ST_DECAY;
         ST_DECAY:   state_in = adam ? ST_MHAT : ST_FIN;
         ST_MHAT:    if (div_stat.done) state_in = ST_VHAT;
         ST_VHAT:    if (div_stat.done) state_in = ST_ROOT;
         ST_ROOT:    if (root_stat.done) state_in = ST_SMUL;
         ST_SMUL:    state_in = (denom_ff == 41'd0) ? ST_FIN : ST_SDIV_GO;
         ST_SDIV_GO: state_in = ST_SDIV;
         ST_SDIV:    if (div_stat.done) state_in = ST_FIN;
         ST_FIN:     state_in = ST_OUT;
         ST_OUT:     if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      div_cmd    = '0;
      root_value = {div_quot[55:0], 24'd0};
      case (state_ff)
         ST_CLEAR: begin
            ctl.we_m = 1'b1;
            ctl.we_v = 1'b1;
         end
         ST_IDLE: ctl.deq = head_valid;
         ST_MUL3: ctl.we_m = 1'b1;
         ST_DECAY: begin
            ctl.we_v      = 1'b1;
            div_cmd.start = adam;
            div_cmd.count = CNT_HAT;
            div_cmd.num   = {m_mag, 49'd0};
            div_cmd.den   = {16'd0, ONE_Q - item_ff.beta1_power};
         end
         ST_MHAT: begin
            div_cmd.start = div_stat.done;
            div_cmd.count = CNT_HAT;
            div_cmd.num   = {v_new_ff, 49'd0};
            div_cmd.den   = {16'd0, ONE_Q - item_ff.beta2_power};
         end
         ST_VHAT: ctl.root_start = div_stat.done;
         ST_SDIV_GO: begin
            div_cmd.start = 1'b1;
            div_cmd.count = CNT_STEP;
            div_cmd.num   = sp_num;
            div_cmd.den   = denom_ff;
         end
         ST_OUT: ctl.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_ptr_ff <= clr_ptr_ff + AW'(1);
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.we_m) begin
         mem_m[wr_addr] <= wr_m;
      end
      if (ctl.we_v) begin
         mem_v[wr_addr] <= clearing ? 32'd0 : v_new_ff;
      end
      if (state_ff == ST_READ) begin
         m_old_ff <= mem_m[addr_ff];
         v_old_ff <= mem_v[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff <= head;
            modq_ff <= modq_prod[36:24];
            sat_ff  <= 1'b0;
         end
         ST_MOD: addr_ff <= mod_fix[AW-1:0];
         ST_MUL1: begin
            pa_ff     <= pa_in;
            pb_ff     <= pb_in;
            g2full_ff <= 64'(g_mag) * 64'(g_mag);
         end
         ST_MUL2: begin
            m_new_ff <= m_hi ? 32'h7FFF_FFFF : (m_lo ? 32'h8000_0000 : m_sh[31:0]);
            sat_ff   <= sat_ff | m_hi | m_lo;
            g2_ff    <= g2full_ff[63:24];
            pv_a_ff  <= 57'(b2) * 57'(v_old_ff);
         end
         ST_MUL3: begin
            pv_lo_ff <= 49'(c2) * 49'(g2_ff[23:0]);
            pv_hi_ff <= 41'(c2) * 41'(g2_ff[39:24]);
         end
         ST_MUL4: begin
            v_new_ff <= v_ovf ? 32'hFFFF_FFFF : v_sh[31:0];
            sat_ff   <= sat_ff | v_ovf;
            dec_ff   <= dec_full[48:24];
         end
         ST_DECAY: begin
            dw_ff   <= dw_in;
            smag_ff <= 41'd0;
         end
         ST_MHAT: if (div_stat.done) mhat_ff <= div_quot[55:0];
         ST_ROOT: if (root_stat.done) denom_ff <= 41'(root_res) + 41'(cfg.guard_term);
         ST_SMUL: begin
            sp_lo_ff <= 53'(cfg.learn_rate) * 53'(mhat_ff[27:0]);
            sp_hi_ff <= 53'(cfg.learn_rate) * 53'(mhat_ff[55:28]);
         end
         ST_SDIV: begin
            if (div_stat.done) begin
               smag_ff <= (div_quot > 81'(STEP_CAP)) ? STEP_CAP : div_quot[40:0];
            end
         end
         ST_FIN: sat_ff <= sat_ff | w_hi | w_lo;
         default: sat_ff <= sat_ff;
      endcase
      if (ctl.rsp_load) begin
         rsp_w_ff   <= w_fin;
         rsp_sat_ff <= sat_ff;
      end
   end

   `ADPU_ASSERT_IMPLY(a_div_free, clock, reset, div_cmd.start, !div_stat.busy)
   `ADPU_ASSERT_IMPLY(a_rsp_slot, clock, reset, ctl.rsp_load, !rsp_valid_ff || rsp_ready)
   `ADPU_ASSERT_NEXT(a_pop_mod, clock, reset, ctl.deq, state_ff == ST_MOD)

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench import adpu_pkg::*;;

   localparam int DEPTH = 4096;
   localparam longint LIMIT = 3000000;
   localparam logic [63:0] UNITY = 64'd1 << 24;

   typedef struct {
      logic [31:0] weight;
      logic        sat;
   } update_type;

   class weight_tracker;
      logic [63:0] lr, b1_reg, b2_reg, eps, wd;
      int          m_mem [DEPTH];
      logic [31:0] v_mem [DEPTH];
      logic [63:0] p1, p2;
      update_type  pending [$];
      int          errors;

      function new();
         lr = 64'(RST_LEARN_RATE);
         b1_reg = 64'(RST_FIRST_DECAY);
         b2_reg = 64'(RST_SECOND_DECAY);
         eps = 64'(RST_GUARD_TERM);
         wd = 64'(RST_DECAY_WEIGHT);
         foreach (m_mem[i]) begin
            m_mem[i] = 0;
            v_mem[i] = 32'd0;
         end
         p1 = UNITY;
         p2 = UNITY;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [24:0] val);
         case (idx)
            CSR_LEARN_RATE: lr = 64'(val);
            CSR_FIRST_DECAY: b1_reg = 64'(val[23:0]);
            CSR_SECOND_DECAY: b2_reg = 64'(val[23:0]);
            CSR_GUARD_TERM: eps = 64'(val);
            CSR_DECAY_WEIGHT: wd = 64'(val);
            default: ;
         endcase
      endfunction

      function logic [127:0] isqrt(logic [127:0] x);
         logic [127:0] root, rem, trial;
         root = 0;
         rem = 0;
         for (int p = 126; p >= 0; p -= 2) begin
            rem = (rem << 2) | ((x >> p) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
               rem = rem - trial;
               root = (root << 1) | 128'd1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function void note_item(logic [11:0] idx, logic [31:0] g, logic [31:0] w, bit np);
         longint gs, ws, m, step, w1, w2, dec;
         logic [63:0] b1, b2, gm, g2, v, mm, mh, vh, s;
         logic [127:0] root, den, num, qt;
         update_type u;
         bit sat;
         b1 = b1_reg > UNITY ? UNITY : b1_reg;
         b2 = b2_reg > UNITY ? UNITY : b2_reg;
         sat = 0;
         step = 0;
         if (np) begin
            p1 = ((p1 * b1) >> 24) & 64'h1FF_FFFF;
            p2 = ((p2 * b2) >> 24) & 64'h1FF_FFFF;
         end
         gs = longint'(signed'(g));
         ws = longint'(signed'(w));
         m = (longint'(b1) * longint'(m_mem[idx]) + longint'(UNITY - b1) * gs) >>> 24;
         if (m > 64'sd2147483647) begin
            m = 64'sd2147483647;
            sat = 1;
         end
         if (m < -64'sd2147483648) begin
            m = -64'sd2147483648;
            sat = 1;
         end
         m_mem[idx] = int'(m);
         gm = gs < 0 ? 64'(-gs) : 64'(gs);
         g2 = (gm * gm) >> 24;
         v = (b2 * 64'(v_mem[idx]) + (UNITY - b2) * g2) >> 24;
         if (v > 64'hFFFF_FFFF) begin
            v = 64'hFFFF_FFFF;
            sat = 1;
         end
         v_mem[idx] = v[31:0];
         if (p1 < UNITY && p2 < UNITY) begin
            mm = m < 0 ? 64'(-m) : 64'(m);
            mh = (mm << 24) / (UNITY - p1);
            vh = (v << 24) / (UNITY - p2);
            root = isqrt(128'(vh) << 24);
            den = root + 128'(eps);
            if (den != 0) begin
               num = 128'(lr) * 128'(mh);
               qt = num / den;
               if (qt > 128'(STEP_CAP)) s = 64'(STEP_CAP);
               else s = qt[63:0];
               step = m < 0 ? -longint'(s) : longint'(s);
            end
         end
         dec = longint'((lr * wd) >> 24);
         w1 = ws - ((dec * ws) >>> 24);
         w2 = w1 - step;
         if (w2 > 64'sd2147483647) begin
            w2 = 64'sd2147483647;
            sat = 1;
         end
         if (w2 < -64'sd2147483648) begin
            w2 = -64'sd2147483648;
            sat = 1;
         end
         u.weight = w2[31:0];
         u.sat = sat;
         pending.insert(pending.size(), u);
      endfunction

      function void check_update(logic [31:0] weight, logic sat);
         update_type u;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: weight %h sat %b", weight, sat);
            return;
         end
         u = pending[0];
         pending.delete(0);
         if (u.weight !== weight || u.sat !== sat) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected weight %h sat %b, got weight %h sat %b",
                        u.weight, u.sat, weight, sat);
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_ready, req_new_pass;
   logic [11:0] req_elem_index;
   logic [31:0] req_gradient, req_weight_in;
   logic        rsp_valid, rsp_ready, rsp_saturated;
   logic [31:0] rsp_weight_out;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [24:0] csr_data;

   weight_tracker tracker = new();
   int     send_pct, recv_pct;
   longint cycles;

   adamw_parameter_update #(.DEPTH(DEPTH)) DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_elem_index, .req_gradient, .req_weight_in, .req_new_pass,
      .rsp_valid, .rsp_ready, .rsp_weight_out, .rsp_saturated,
      .csr_write_en, .csr_index, .csr_data
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) tracker.check_update(rsp_weight_out, rsp_saturated);
         rsp_ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   task automatic send_item(logic [11:0] idx, logic [31:0] g, logic [31:0] w, bit np);
      if (!req_valid || $urandom_range(99) < send_pct) begin
         if (req_valid) begin
            req_valid <= 0;
            @(posedge clock);
         end
         while ($urandom_range(99) < send_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_elem_index <= idx;
      req_gradient <= g;
      req_weight_in <= w;
      req_new_pass <= np;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(idx, g, w, np);
   endtask

   task automatic drain();
      if (req_valid) begin
         req_valid <= 0;
         @(posedge clock);
      end
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [24:0] val);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      tracker.set_reg(idx, val);
   endtask

   task automatic set_all(logic [24:0] lr, logic [24:0] b1, logic [24:0] b2,
                          logic [24:0] eps, logic [24:0] wd);
      drain();
      write_reg(CSR_LEARN_RATE, lr);
      write_reg(CSR_FIRST_DECAY, b1);
      write_reg(CSR_SECOND_DECAY, b2);
      write_reg(CSR_GUARD_TERM, eps);
      write_reg(CSR_DECAY_WEIGHT, wd);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(67108864)) - 33554432);
         2: return 32'($signed($urandom_range(2000)) - 1000);
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   task automatic random_items(int count);
      logic [11:0] idx;
      for (int i = 0; i < count; i++) begin
         idx = $urandom_range(9) == 0 ? 12'($urandom) : 12'($urandom_range(15));
         send_item(idx, rand_value(), rand_value(), $urandom_range(15) == 0);
      end
   endtask

   initial begin
      cycles = 0;
      reset = 1;
      req_valid = 0;
      req_elem_index = 0;
      req_gradient = 0;
      req_weight_in = 0;
      req_new_pass = 0;
      csr_write_en = 0;
      csr_index = 0;
      csr_data = 0;
      send_pct = 20;
      recv_pct = 53;
      repeat (12) @(posedge clock);
      reset <= 0;

      // powers still one: the first items get only moments and decay, until a new pass
      send_item(12'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_item(12'd4095, 32'h8000_0000, 32'h8000_0000, 0);
      send_item(12'd1, 32'h0, 32'h0100_0000, 0);
      send_item(12'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1);
      send_item(12'd4095, 32'h7FFF_FFFF, 32'h0000_0001, 0);
      send_item(12'd2, 32'h0100_0000, 32'h8000_0000, 0);
      send_item(12'd3, 32'hFF00_0000, 32'h7FFF_FFFF, 1);
      // zero denominator: zero moments and zero guard term
      set_all(25'd16777216, 25'd0, 25'd0, 25'd0, 25'd0);
      send_item(12'd100, 32'h0, 32'h1234_5678, 1);
      send_item(12'd100, 32'h0, 32'hEDCB_A988, 0);
      send_item(12'd101, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_item(12'd101, 32'h8000_0000, 32'h7FFF_FFFF, 1);
      set_all(25'd16777216, 25'hFF_FFFF, 25'hFF_FFFF, 25'd16777216, 25'd16777216);
      send_item(12'd200, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_item(12'd200, 32'h8000_0000, 32'h8000_0000, 0);
      send_item(12'd4095, 32'h0000_0001, 32'hFFFF_FFFF, 1);
      send_item(12'd201, 32'hFFFF_FFFF, 32'h0, 0);

      set_all(RST_LEARN_RATE, 25'(RST_FIRST_DECAY), 25'(RST_SECOND_DECAY), RST_GUARD_TERM,
              RST_DECAY_WEIGHT);
      random_items(400);
      send_pct = 53;
      recv_pct = 20;
      set_all(25'd0, 25'd8388608, 25'd16000000, 25'd1000, 25'd16777216);
      random_items(350);
      set_all(25'($urandom_range(16777216)), 25'($urandom_range(16777215)),
              25'($urandom_range(16777215)), 25'($urandom_range(16777216)),
              25'($urandom_range(16777216)));
      random_items(350);
      send_pct = 0;
      recv_pct = 0;
      set_all(25'd16777216, 25'd15099494, 25'd16760439, 25'd1, 25'd0);
      random_items(350);
      drain();
      set_all(25'($urandom_range(1677721)), 25'($urandom_range(16777215)),
              25'($urandom_range(16777215)), 25'($urandom_range(65536)),
              25'($urandom_range(1677721)));
      random_items(250);
      drain();

      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
